// ===== rtl/fgcr_pkg.sv =====
`default_nettype none

package fgcr_pkg;

  localparam int GLYPH_STORE_BYTES = 4096;
  localparam int CHAR_CODES        = 256;

  localparam int SA_W      = $clog2(GLYPH_STORE_BYTES);
  localparam int IA_W      = $clog2(CHAR_CODES);
  localparam int ROW_BYTES = 32;
  localparam int RB_W      = $clog2(ROW_BYTES);
  localparam int ROW_W     = ROW_BYTES * 8;

  typedef enum logic [1:0] {
    FUNC_LOAD_INDEX = 2'd0,
    FUNC_LOAD_BYTE  = 2'd1,
    FUNC_SET_CURSOR = 2'd2,
    FUNC_DRAW       = 2'd3
  } func_t;

  typedef enum logic {
    CFG_INVERSE_ENABLE = 1'b0,
    CFG_INVERSE_MASK   = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic            clear;
    logic            put;
    logic [RB_W-1:0] pos;
    logic [7:0]      data;
  } row_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/fgcr_row_asm.sv =====
`default_nettype none

module fgcr_row_asm (
  input  wire logic                      clk,
  input  wire fgcr_pkg::row_ctl_t        ctl,
  input  wire logic                      inv_en,
  input  wire logic [7:0]                inv_mask,
  output logic [fgcr_pkg::ROW_W-1:0]     row_bytes
);

  logic [fgcr_pkg::ROW_W-1:0] row_r;
  logic [fgcr_pkg::ROW_W-1:0] row_nxt;
  logic [7:0]                 spacer;
  logic [7:0]                 pixel;
  logic [fgcr_pkg::RB_W+2:0]  bit_pos;

  assign spacer  = inv_en ? inv_mask : 8'h00;
  assign pixel   = inv_en ? (~ctl.data & inv_mask) : ctl.data;
  assign bit_pos = {ctl.pos, 3'b000};

  always_comb begin
    row_nxt = row_r;
    if (ctl.clear) begin
      row_nxt = '0;
      row_nxt[bit_pos +: 8] = spacer;
    end else if (ctl.put) begin
      row_nxt[bit_pos +: 8] = pixel;
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
  end

  assign row_bytes = row_r;

endmodule

`default_nettype wire

// ===== rtl/font_glyph_column_renderer.sv =====
// Load and cursor items are handled in the idle state and keep in_ready high.
// A draw reads the index and the glyph header, then per row reads its bytes and
// emits the row, one glyph store read per cycle through the single read port while
// no row waits for out_ready; in_ready stays low until the last row is emitted.
// Synchronous active-low reset clears cursor, inverse settings and control;
// index table and glyph store hold no reset value and must be loaded before use.
`default_nettype none

module font_glyph_column_renderer (
  input  wire logic        clk,
  input  wire logic        rst_n,

  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [7:0]  cfg_wdata,

  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_func,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [11:0] in_glyph_address,
  input  wire logic [7:0]  in_glyph_byte,
  input  wire logic [7:0]  in_cursor_row,
  input  wire logic [7:0]  in_cursor_column,

  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_row,
  output logic [7:0]       out_column,
  output logic [5:0]       out_byte_count,
  output logic [63:0]      out_bytes_lo,
  output logic [63:0]      out_bytes_mid_lo,
  output logic [63:0]      out_bytes_mid_hi,
  output logic [63:0]      out_bytes_hi,
  output logic             out_last_row
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_IDX,
    S_HDR,
    S_BYTE,
    S_EMIT
  } state_t;

  localparam int SA_W = fgcr_pkg::SA_W;
  localparam int IA_W = fgcr_pkg::IA_W;

  logic [11:0] idx_mem [fgcr_pkg::CHAR_CODES];
  logic [7:0]  st_mem  [fgcr_pkg::GLYPH_STORE_BYTES];

  logic [11:0]     idx_rd_r;
  logic [7:0]      st_rd_r;
  logic            st_re;
  logic [SA_W-1:0] st_raddr;

  state_t          state_r,     state_nxt;
  logic [7:0]      row_pos_r,   row_pos_nxt;
  logic [7:0]      col_pos_r,   col_pos_nxt;
  logic            inv_en_r;
  logic [7:0]      inv_mask_r;
  logic [SA_W-1:0] ptr_r,       ptr_nxt;
  logic [4:0]      width_r,     width_nxt;
  logic [1:0]      rows_m1_r,   rows_m1_nxt;
  logic [1:0]      row_idx_r,   row_idx_nxt;
  logic [4:0]      k_r,         k_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic            out_load;
  logic [7:0]      out_row_r;
  logic [7:0]      out_column_r;
  logic [5:0]      out_byte_count_r;
  logic [63:0]     out_bytes_lo_r;
  logic [63:0]     out_bytes_mid_lo_r;
  logic [63:0]     out_bytes_mid_hi_r;
  logic [63:0]     out_bytes_hi_r;
  logic            out_last_row_r;

  fgcr_pkg::row_ctl_t             row_ctl;
  logic [fgcr_pkg::ROW_W-1:0]     row_bytes;

  logic in_xfer;
  logic code_ok;

  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign code_ok  = 32'(in_char_code) < fgcr_pkg::CHAR_CODES;

  always_ff @(posedge clk) begin
    if (in_xfer && in_func == fgcr_pkg::FUNC_LOAD_INDEX && code_ok) begin
      idx_mem[in_char_code[IA_W-1:0]] <= in_glyph_address;
    end
    if (in_xfer) begin
      idx_rd_r <= idx_mem[in_char_code[IA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && in_func == fgcr_pkg::FUNC_LOAD_BYTE) begin
      st_mem[SA_W'(in_glyph_address)] <= in_glyph_byte;
    end
    if (st_re) begin
      st_rd_r <= st_mem[st_raddr];
    end
  end

  fgcr_row_asm u_row_asm (
    .clk       (clk),
    .ctl       (row_ctl),
    .inv_en    (inv_en_r),
    .inv_mask  (inv_mask_r),
    .row_bytes (row_bytes)
  );

  always_comb begin
    state_nxt     = state_r;
    row_pos_nxt   = row_pos_r;
    col_pos_nxt   = col_pos_r;
    ptr_nxt       = ptr_r;
    width_nxt     = width_r;
    rows_m1_nxt   = rows_m1_r;
    row_idx_nxt   = row_idx_r;
    k_nxt         = k_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load      = 1'b0;
    st_re         = 1'b0;
    st_raddr      = ptr_r;
    row_ctl       = '0;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_func == fgcr_pkg::FUNC_SET_CURSOR) begin
            row_pos_nxt = in_cursor_row;
            col_pos_nxt = in_cursor_column;
          end else if (in_func == fgcr_pkg::FUNC_DRAW && code_ok) begin
            state_nxt = S_IDX;
          end
        end
      end
      S_IDX: begin
        st_re     = 1'b1;
        st_raddr  = SA_W'(idx_rd_r);
        ptr_nxt   = SA_W'(idx_rd_r) + SA_W'(1);
        state_nxt = S_HDR;
      end
      S_HDR: begin
        width_nxt    = st_rd_r[4:0];
        rows_m1_nxt  = st_rd_r[7:6];
        row_idx_nxt  = 2'd0;
        k_nxt        = 5'd0;
        row_ctl.clear = 1'b1;
        row_ctl.pos   = st_rd_r[4:0];
        if (st_rd_r[4:0] != 5'd0) begin
          st_re     = 1'b1;
          ptr_nxt   = ptr_r + SA_W'(1);
          state_nxt = S_BYTE;
        end else begin
          state_nxt = S_EMIT;
        end
      end
      S_BYTE: begin
        row_ctl.put  = 1'b1;
        row_ctl.pos  = k_r;
        row_ctl.data = st_rd_r;
        if (k_r == width_r - 5'd1) begin
          state_nxt = S_EMIT;
        end else begin
          st_re   = 1'b1;
          ptr_nxt = ptr_r + SA_W'(1);
          k_nxt   = k_r + 5'd1;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          if (row_idx_r == rows_m1_r) begin
            col_pos_nxt = col_pos_r + 8'(width_r) + 8'd1;
            state_nxt   = S_IDLE;
          end else begin
            row_idx_nxt   = row_idx_r + 2'd1;
            k_nxt         = 5'd0;
            row_ctl.clear = 1'b1;
            row_ctl.pos   = width_r;
            if (width_r != 5'd0) begin
              st_re     = 1'b1;
              ptr_nxt   = ptr_r + SA_W'(1);
              state_nxt = S_BYTE;
            end
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_pos_r   <= 8'd0;
      col_pos_r   <= 8'd0;
      inv_en_r    <= 1'b0;
      inv_mask_r  <= 8'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_pos_r   <= row_pos_nxt;
      col_pos_r   <= col_pos_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          fgcr_pkg::CFG_INVERSE_ENABLE: inv_en_r   <= cfg_wdata[0];
          fgcr_pkg::CFG_INVERSE_MASK:   inv_mask_r <= cfg_wdata;
          default:                      inv_en_r   <= inv_en_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr_r     <= ptr_nxt;
    width_r   <= width_nxt;
    rows_m1_r <= rows_m1_nxt;
    row_idx_r <= row_idx_nxt;
    k_r       <= k_nxt;
    if (out_load) begin
      out_row_r          <= row_pos_r + 8'(row_idx_r);
      out_column_r       <= col_pos_r;
      out_byte_count_r   <= 6'(width_r) + 6'd1;
      out_bytes_lo_r     <= row_bytes[63:0];
      out_bytes_mid_lo_r <= row_bytes[127:64];
      out_bytes_mid_hi_r <= row_bytes[191:128];
      out_bytes_hi_r     <= row_bytes[255:192];
      out_last_row_r     <= (row_idx_r == rows_m1_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_row          = out_row_r;
  assign out_column       = out_column_r;
  assign out_byte_count   = out_byte_count_r;
  assign out_bytes_lo     = out_bytes_lo_r;
  assign out_bytes_mid_lo = out_bytes_mid_lo_r;
  assign out_bytes_mid_hi = out_bytes_mid_hi_r;
  assign out_bytes_hi     = out_bytes_hi_r;
  assign out_last_row     = out_last_row_r;

endmodule

`default_nettype wire

// ===== bench/tb_font_glyph_column_renderer.sv =====
module tb_font_glyph_column_renderer;

  localparam int CYCLE_LIMIT = 1000000;

  typedef struct packed {
    logic [7:0]   row;
    logic [7:0]   col;
    logic [5:0]   count;
    logic [255:0] bits;
    logic         last;
  } cell_row_t;

  typedef struct packed {
    fgcr_pkg::func_t f;
    logic [7:0]      code;
    logic [11:0]     addr;
    logic [7:0]      gbyte;
    logic [7:0]      crow;
    logic [7:0]      ccol;
    logic            typed;
    cell_row_t       res;
  } script_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [7:0]  cfg_wdata = 8'h00;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = 2'b00;
  logic [7:0]  in_char_code = 8'h00;
  logic [11:0] in_glyph_address = 12'h000;
  logic [7:0]  in_glyph_byte = 8'h00;
  logic [7:0]  in_cursor_row = 8'h00;
  logic [7:0]  in_cursor_column = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_row;
  logic [7:0]  out_column;
  logic [5:0]  out_byte_count;
  logic [63:0] out_bytes_lo;
  logic [63:0] out_bytes_mid_lo;
  logic [63:0] out_bytes_mid_hi;
  logic [63:0] out_bytes_hi;
  logic        out_last_row;

  logic [11:0] index_table [256];
  bit          index_set [256];
  logic [7:0]  glyph_mem [4096];
  bit          mem_set [4096];
  logic [7:0]  cursor_row = 8'h00;
  logic [7:0]  cursor_col = 8'h00;
  logic        inverse_on = 1'b0;
  logic [7:0]  inverse_mask = 8'h00;

  cell_row_t   expected_rows [$];
  logic [7:0]  ready_codes [$];
  script_row_t script [18];

  int send_gap = 30;
  int recv_gap = 45;
  int items_sent = 0;
  int draws_sent = 0;
  int rows_checked = 0;
  int errors = 0;
  int cycle_count = 0;

  font_glyph_column_renderer u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_char_code     (in_char_code),
    .in_glyph_address (in_glyph_address),
    .in_glyph_byte    (in_glyph_byte),
    .in_cursor_row    (in_cursor_row),
    .in_cursor_column (in_cursor_column),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_row          (out_row),
    .out_column       (out_column),
    .out_byte_count   (out_byte_count),
    .out_bytes_lo     (out_bytes_lo),
    .out_bytes_mid_lo (out_bytes_mid_lo),
    .out_bytes_mid_hi (out_bytes_mid_hi),
    .out_bytes_hi     (out_bytes_hi),
    .out_last_row     (out_last_row)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    out_ready <= ($urandom_range(99) >= recv_gap);
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  function automatic bit draw_ok(logic [7:0] code);
    logic [11:0] a;
    logic [7:0]  hdr;
    int          n;
    if (!index_set[code]) return 1'b0;
    a = index_table[code];
    if (!mem_set[a]) return 1'b0;
    hdr = glyph_mem[a];
    n = int'(hdr[4:0]) * (int'(hdr[7:6]) + 1);
    for (int k = 0; k < n; k++) begin
      a = a + 12'd1;
      if (!mem_set[a]) return 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic render_item(fgcr_pkg::func_t f, logic [7:0] code, logic [11:0] addr,
                             logic [7:0] gbyte, logic [7:0] crow, logic [7:0] ccol,
                             bit keep_rows);
    logic [11:0] ptr;
    logic [7:0]  hdr;
    logic [7:0]  b;
    logic [7:0]  spacer;
    int          w;
    int          nr;
    cell_row_t   cr;
    case (f)
      fgcr_pkg::FUNC_LOAD_INDEX: begin
        index_table[code] = addr;
        index_set[code] = 1'b1;
      end
      fgcr_pkg::FUNC_LOAD_BYTE: begin
        glyph_mem[addr] = gbyte;
        mem_set[addr] = 1'b1;
      end
      fgcr_pkg::FUNC_SET_CURSOR: begin
        cursor_row = crow;
        cursor_col = ccol;
      end
      default: begin
        ptr = index_table[code];
        hdr = glyph_mem[ptr];
        w = int'(hdr[4:0]);
        nr = int'(hdr[7:6]) + 1;
        spacer = inverse_on ? inverse_mask : 8'h00;
        for (int r = 0; r < nr; r++) begin
          cr.bits = '0;
          for (int k = 0; k < w; k++) begin
            ptr = ptr + 12'd1;
            b = glyph_mem[ptr];
            if (inverse_on) b = ~b & inverse_mask;
            cr.bits[8*k +: 8] = b;
          end
          cr.bits[8*w +: 8] = spacer;
          cr.row = cursor_row + 8'(r);
          cr.col = cursor_col;
          cr.count = 6'(w + 1);
          cr.last = (r == nr - 1);
          if (keep_rows) expected_rows.push_back(cr);
        end
        cursor_col = cursor_col + 8'(w + 1);
      end
    endcase
  endtask

  task automatic send_item(fgcr_pkg::func_t f, logic [7:0] code, logic [11:0] addr,
                           logic [7:0] gbyte, logic [7:0] crow, logic [7:0] ccol,
                           input logic typed = 1'b0, input cell_row_t res = '0);
    while ($urandom_range(99) < send_gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_char_code <= (f == fgcr_pkg::FUNC_LOAD_INDEX || f == fgcr_pkg::FUNC_DRAW)
                    ? code : 8'($urandom);
    in_glyph_address <= (f == fgcr_pkg::FUNC_LOAD_INDEX || f == fgcr_pkg::FUNC_LOAD_BYTE)
                        ? addr : 12'($urandom);
    in_glyph_byte <= (f == fgcr_pkg::FUNC_LOAD_BYTE) ? gbyte : 8'($urandom);
    in_cursor_row <= (f == fgcr_pkg::FUNC_SET_CURSOR) ? crow : 8'($urandom);
    in_cursor_column <= (f == fgcr_pkg::FUNC_SET_CURSOR) ? ccol : 8'($urandom);
    do @(negedge clk); while (!in_ready);
    render_item(f, code, addr, gbyte, crow, ccol, !typed);
    if (typed) expected_rows.push_back(res);
    items_sent++;
    if (f == fgcr_pkg::FUNC_DRAW) draws_sent++;
    @(posedge clk);
  endtask

  task automatic set_mode(logic [7:0] en_val, logic [7:0] mask_val);
    cfg_we <= 1'b1;
    cfg_index <= fgcr_pkg::CFG_INVERSE_ENABLE;
    cfg_wdata <= en_val;
    @(posedge clk);
    cfg_index <= fgcr_pkg::CFG_INVERSE_MASK;
    cfg_wdata <= mask_val;
    @(posedge clk);
    cfg_we <= 1'b0;
    inverse_on = en_val[0];
    inverse_mask = mask_val;
  endtask

  task automatic drain(int quiet_cycles);
    in_valid <= 1'b0;
    while (expected_rows.size() != 0) @(posedge clk);
    repeat (quiet_cycles) @(posedge clk);
  endtask

  task automatic build_glyph(int w, int nr, int keep, bit draw_it);
    logic [7:0]  code;
    logic [11:0] base;
    logic [7:0]  hdr;
    code = 8'($urandom);
    base = 12'($urandom);
    hdr = {2'(nr - 1), 1'($urandom), 5'(w)};
    send_item(fgcr_pkg::FUNC_LOAD_INDEX, code, base, 8'h00, 8'h00, 8'h00);
    send_item(fgcr_pkg::FUNC_LOAD_BYTE, 8'h00, base, hdr, 8'h00, 8'h00);
    for (int k = 1; k <= keep; k++)
      send_item(fgcr_pkg::FUNC_LOAD_BYTE, 8'h00, base + 12'(k), 8'($urandom), 8'h00,
                8'h00);
    if (draw_it) begin
      if ($urandom_range(3) == 0)
        send_item(fgcr_pkg::FUNC_SET_CURSOR, 8'h00, 12'h000, 8'h00, 8'($urandom),
                  8'($urandom));
      send_item(fgcr_pkg::FUNC_DRAW, code, 12'h000, 8'h00, 8'h00, 8'h00);
      ready_codes.push_back(code);
    end
  endtask

  task automatic random_traffic(int budget, bit add_largest);
    int         stop;
    int         pick;
    int         w;
    int         nr;
    logic [7:0] code;
    stop = items_sent + budget;
    if (add_largest) build_glyph(31, 4, 124, 1'b1);
    while (items_sent < stop) begin
      pick = $urandom_range(99);
      w = ($urandom_range(19) == 0) ? $urandom_range(31, 7) : $urandom_range(6, 0);
      nr = $urandom_range(4, 1);
      if (pick < 45) begin
        build_glyph(w, nr, w * nr, 1'b1);
      end else if (pick < 75) begin
        if (ready_codes.size() > 0) begin
          code = ready_codes[$urandom_range(ready_codes.size() - 1)];
          if (draw_ok(code)) begin
            if ($urandom_range(2) == 0)
              send_item(fgcr_pkg::FUNC_SET_CURSOR, 8'h00, 12'h000, 8'h00, 8'($urandom),
                        8'($urandom));
            send_item(fgcr_pkg::FUNC_DRAW, code, 12'h000, 8'h00, 8'h00, 8'h00);
          end
        end
      end else if (pick < 90) begin
        case ($urandom_range(2))
          0: send_item(fgcr_pkg::FUNC_LOAD_BYTE, 8'h00, 12'($urandom), 8'($urandom),
                       8'h00, 8'h00);
          1: send_item(fgcr_pkg::FUNC_LOAD_INDEX, 8'($urandom), 12'($urandom), 8'h00,
                       8'h00, 8'h00);
          default: send_item(fgcr_pkg::FUNC_SET_CURSOR, 8'h00, 12'h000, 8'h00,
                             8'($urandom), 8'($urandom));
        endcase
      end else begin
        // truncated glyph, never drawn
        build_glyph(w, nr, (w * nr > 0) ? $urandom_range(w * nr - 1) : 0, 1'b0);
      end
    end
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(negedge clk) begin : watch_results
    cell_row_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_rows.size() == 0) begin
        $display("%0t: unexpected transfer, expected none got row %h col %h", $time,
                 out_row, out_column);
        errors++;
      end else begin
        want = expected_rows.pop_front();
        check_field("out_row", 64'(want.row), 64'(out_row));
        check_field("out_column", 64'(want.col), 64'(out_column));
        check_field("out_byte_count", 64'(want.count), 64'(out_byte_count));
        check_field("out_bytes_lo", want.bits[63:0], out_bytes_lo);
        check_field("out_bytes_mid_lo", want.bits[127:64], out_bytes_mid_lo);
        check_field("out_bytes_mid_hi", want.bits[191:128], out_bytes_mid_hi);
        check_field("out_bytes_hi", want.bits[255:192], out_bytes_hi);
        check_field("out_last_row", 64'(want.last), 64'(out_last_row));
        rows_checked++;
      end
    end
  end

  initial begin
    logic [7:0] phase_en [6];
    logic [7:0] phase_mask [6];
    phase_en = '{8'h01, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h01};
    phase_mask = '{8'hFF, 8'h5A, 8'h00, 8'($urandom), 8'($urandom), 8'hC3};
    script = '{
      '{fgcr_pkg::FUNC_LOAD_INDEX, 8'h00, 12'h000, 8'h00, 8'h00, 8'h00, 1'b0, '0},
      '{fgcr_pkg::FUNC_LOAD_BYTE,  8'h00, 12'h000, 8'h00, 8'h00, 8'h00, 1'b0, '0},
      '{fgcr_pkg::FUNC_DRAW,       8'h00, 12'h000, 8'h00, 8'h00, 8'h00, 1'b1,
        '{8'h00, 8'h00, 6'd1, 256'h0, 1'b1}},
      '{fgcr_pkg::FUNC_LOAD_INDEX, 8'hFF, 12'hFFF, 8'h00, 8'h00, 8'h00, 1'b0, '0},
      '{fgcr_pkg::FUNC_LOAD_BYTE,  8'h00, 12'hFFF, 8'h22, 8'h00, 8'h00, 1'b0, '0},
      '{fgcr_pkg::FUNC_LOAD_BYTE,  8'h00, 12'h000, 8'hA5, 8'h00, 8'h00, 1'b0, '0},
      '{fgcr_pkg::FUNC_LOAD_BYTE,  8'h00, 12'h001, 8'h5A, 8'h00, 8'h00, 1'b0, '0},
      '{fgcr_pkg::FUNC_SET_CURSOR, 8'h00, 12'h000, 8'h00, 8'hFF, 8'hFF, 1'b0, '0},
      '{fgcr_pkg::FUNC_DRAW,       8'hFF, 12'h000, 8'h00, 8'h00, 8'h00, 1'b1,
        '{8'hFF, 8'hFF, 6'd3, 256'h5AA5, 1'b1}},
      '{fgcr_pkg::FUNC_LOAD_INDEX, 8'h41, 12'h800, 8'h00, 8'h00, 8'h00, 1'b0, '0},
      '{fgcr_pkg::FUNC_LOAD_BYTE,  8'h00, 12'h800, 8'h41, 8'h00, 8'h00, 1'b0, '0},
      '{fgcr_pkg::FUNC_LOAD_BYTE,  8'h00, 12'h801, 8'h80, 8'h00, 8'h00, 1'b0, '0},
      '{fgcr_pkg::FUNC_LOAD_BYTE,  8'h00, 12'h802, 8'h01, 8'h00, 8'h00, 1'b0, '0},
      '{fgcr_pkg::FUNC_DRAW,       8'h41, 12'h000, 8'h00, 8'h00, 8'h00, 1'b0, '0},
      '{fgcr_pkg::FUNC_SET_CURSOR, 8'h00, 12'h000, 8'h00, 8'h00, 8'h00, 1'b0, '0},
      '{fgcr_pkg::FUNC_DRAW,       8'hFF, 12'h000, 8'h00, 8'h00, 8'h00, 1'b0, '0},
      '{fgcr_pkg::FUNC_LOAD_BYTE,  8'h00, 12'h000, 8'h00, 8'h00, 8'h00, 1'b0, '0},
      '{fgcr_pkg::FUNC_DRAW,       8'h00, 12'h000, 8'h00, 8'h00, 8'h00, 1'b0, '0}
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    set_mode(8'hFE, 8'h00);
    for (int i = 0; i < 18; i++)
      send_item(script[i].f, script[i].code, script[i].addr, script[i].gbyte,
                script[i].crow, script[i].ccol, script[i].typed, script[i].res);
    drain(20);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 2) begin
        send_gap = 45;
        recv_gap = 30;
      end else if (ph == 4) begin
        send_gap = 0;
        recv_gap = 0;
      end
      set_mode(phase_en[ph], phase_mask[ph]);
      random_traffic(75, ph == 5);
      drain(20);
    end

    drain(150);
    errors = errors + expected_rows.size();
    $display("Sent %0d items including %0d draws, checked %0d glyph rows", items_sent,
             draws_sent, rows_checked);
    $display("Six inverse settings, three idle profiles, %0d cycles, %0d errors",
             cycle_count, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
